// ===== rtl/sorted_priority_queue_assert.svh =====
// Assertion macros for the RTL, included by the queue top file
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// checked outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

   localparam int DATA_W       = 32;
   localparam int OCC_W        = 8;
   localparam int CAPACITY_DEF = 128;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prio;
      logic signed [DATA_W-1:0] val;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic remove;
   } cell_cmd_type;

endpackage

// ===== rtl/spq_cell.sv =====
module spq_cell (
   input  logic                 clock,
   input  spq_pkg::cell_cmd_type cmd,
   input  spq_pkg::entry_type    new_entry,
   input  spq_pkg::entry_type    left_entry,
   input  spq_pkg::entry_type    right_entry,
   input  logic                 left_keep,
   input  logic                 occupied,
   output spq_pkg::entry_type    entry,
   output logic                 keep
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // hold when this entry is occupied and ranks equal or higher than the newcomer
   assign keep = occupied && ($signed(entry_ff.prio) >= $signed(new_entry.prio));

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert && !keep) begin
         if (left_keep) begin
            entry_in = new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (cmd.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Channel   Ports                         Role
// req       req_tvalid/tready/tdata/tuser insert or remove request in
// rsp       rsp_tvalid/tready/tdata/tuser one result out per request
//
// One request per cycle unless a result stalls; the result shows in the next cycle.
// The row of CAPACITY cells shifts right on insert and left on remove, all cells together.
// Reset clears the entry count and the result valid flag; cell contents stay undefined.
// A stalled result holds the register; a new request is taken only once it leaves.
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // item_value[31:0], item_priority[63:32], zero[71:64]
   input  logic [0:0]  req_tuser,  // operation[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // removed_value[31:0], removed_priority[63:32],
                                   // occupancy[71:64]
   output logic [1:0]  rsp_tuser   // status[1:0]
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   status_type             rsp_status_ff;
   status_type             rsp_status_in;
   logic [DATA_W-1:0]      rsp_val_ff;
   logic [DATA_W-1:0]      rsp_val_in;
   logic [DATA_W-1:0]      rsp_prio_ff;
   logic [DATA_W-1:0]      rsp_prio_in;
   logic [OCC_W-1:0]       rsp_occ_ff;
   logic [OCC_W-1:0]       rsp_occ_in;

   logic                   accept;
   logic                   full;
   logic                   empty;
   op_type                 op;
   entry_type              new_entry;
   entry_type              head;
   cell_cmd_type           cmd;
   entry_type              entries [CAPACITY];
   logic                   keeps   [CAPACITY];

   assign op             = op_type'(req_tuser[0]);
   assign new_entry.val  = req_tdata[DATA_W-1:0];
   assign new_entry.prio = req_tdata[2*DATA_W-1:DATA_W];
   assign req_tready     = !rsp_valid_ff || rsp_tready;
   assign accept         = req_tvalid && req_tready;
   assign full           = (count_ff == CNT_W'(CAPACITY));
   assign empty          = (count_ff == '0);
   assign cmd.insert     = accept && (op == OP_INSERT) && !full;
   assign cmd.remove     = accept && (op == OP_REMOVE) && !empty;
   assign head           = entries[0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
      entry_type left_entry;
      entry_type right_entry;
      logic      left_keep;

      if (i == 0) begin : g_first
         assign left_entry = new_entry;
         assign left_keep  = 1'b1;
      end else begin : g_mid
         assign left_entry = entries[i-1];
         assign left_keep  = keeps[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entries[i];
      end else begin : g_inner
         assign right_entry = entries[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .left_keep   (left_keep),
         .occupied    (IDX < count_ff),
         .entry       (entries[i]),
         .keep        (keeps[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      unique case (op)
         OP_INSERT: rsp_status_in = full ? ST_FULL : ST_DONE;
         OP_REMOVE: rsp_status_in = empty ? ST_EMPTY : ST_DONE;
         default:   rsp_status_in = ST_DONE;
      endcase
      rsp_val_in  = cmd.remove ? head.val : '0;
      rsp_prio_in = cmd.remove ? head.prio : '0;
      rsp_occ_in  = OCC_W'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_val_ff    <= rsp_val_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_occ_ff, rsp_prio_ff, rsp_val_ff};
   assign rsp_tuser  = rsp_status_ff;

   `SPQ_ASSERT(a_count_bound, count_ff <= CNT_W'(CAPACITY), "entry count above capacity")
   `SPQ_ASSERT(a_insert_count, cmd.insert |=> count_ff == $past(count_ff) + CNT_W'(1), "insert did not advance count")
   `SPQ_ASSERT(a_head_out, cmd.remove |=> rsp_tdata[2*DATA_W-1:DATA_W] == $past(head.prio), "removed priority is not the head")
   `SPQ_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH  = CAPACITY_DEF;
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 156;
   localparam int PHASE_COUNT  = 9;
   localparam int DIRECTED_CNT = 18;

   typedef struct {
      status_type  status;
      logic [31:0] val;
      logic [31:0] prio;
      logic [7:0]  occ;
   } queue_result;

   typedef struct {
      op_type      op;
      logic [31:0] val;
      logic [31:0] prio;
      bit          typed;
      queue_result res;
   } stim_row;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   logic signed [31:0] held_val[$];
   logic signed [31:0] held_prio[$];
   queue_result        pending_results[$];

   bit steady = 1'b0;
   int fail_count = 0;
   int stall_cycles = 0;
   int n_insert = 0;
   int n_remove = 0;
   int n_full = 0;
   int n_empty = 0;
   int peak_occ = 0;

   stim_row directed_rows[DIRECTED_CNT];
   int      insert_share[PHASE_COUNT] = '{90, 10, 50, 95, 5, 60, 40, 90, 10};

   sorted_priority_queue #(.CAPACITY(QUEUE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic queue_result apply_to_queue(op_type op, logic signed [31:0] val,
                                                  logic signed [31:0] prio);
      queue_result r;
      int pos;
      r.status = ST_DONE;
      r.val = '0;
      r.prio = '0;
      pos = 0;
      if (op == OP_INSERT) begin
         n_insert++;
         if (held_prio.size() >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
            n_full++;
         end else begin
            while (pos < held_prio.size() && held_prio[pos] >= prio) pos++;
            held_prio.insert(pos, prio);
            held_val.insert(pos, val);
         end
      end else begin
         n_remove++;
         if (held_prio.size() == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
         end else begin
            r.val = held_val.pop_front();
            r.prio = held_prio.pop_front();
         end
      end
      r.occ = 8'(held_prio.size());
      if (held_prio.size() > peak_occ) peak_occ = held_prio.size();
      return r;
   endfunction

   task automatic issue_request(op_type op, logic [31:0] val, logic [31:0] prio, bit typed,
                                queue_result given);
      queue_result r;
      if (!steady) begin
         while ($urandom_range(0, 99) < 20) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {8'h00, prio, val};
      do @(posedge clock); while (!req_tready);
      r = apply_to_queue(op, val, prio);
      pending_results.push_back(typed ? given : r);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 20);
   end

   always @(posedge clock) begin : check_results
      queue_result want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no expectation waiting");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[31:0] !== want.val) begin
               $error("removed_value: expected %h, got %h", want.val, rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[63:32] !== want.prio) begin
               $error("removed_priority: expected %h, got %h", want.prio, rsp_tdata[63:32]);
               fail_count++;
            end
            if (rsp_tdata[71:64] !== want.occ) begin
               $error("occupancy: expected %0d, got %0d", want.occ, rsp_tdata[71:64]);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      op_type      op;
      logic [31:0] v;
      logic [31:0] p;
      queue_result none;

      none = '{ST_DONE, 32'h0, 32'h0, 8'd0};
      directed_rows = '{
         '{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 32'h0, 8'd0}},
         '{OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, '{ST_DONE, 32'h0, 32'h0, 8'd1}},
         '{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1,
           '{ST_DONE, 32'h7fff_ffff, 32'h7fff_ffff, 8'd0}},
         '{OP_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b1, '{ST_DONE, 32'h0, 32'h0, 8'd1}},
         '{OP_INSERT, 32'h0000_0000, 32'h7fff_ffff, 1'b1, '{ST_DONE, 32'h0, 32'h0, 8'd2}},
         '{OP_INSERT, 32'hffff_ffff, 32'h0000_0000, 1'b1, '{ST_DONE, 32'h0, 32'h0, 8'd3}},
         '{OP_INSERT, 32'h0000_0001, 32'hffff_ffff, 1'b0, none},
         '{OP_INSERT, 32'h0000_0002, 32'h0000_0000, 1'b0, none},
         '{OP_INSERT, 32'h0000_0003, 32'h8000_0000, 1'b0, none},
         '{OP_INSERT, 32'h0000_0004, 32'h7fff_ffff, 1'b0, none},
         '{OP_REMOVE, 32'hffff_ffff, 32'hffff_ffff, 1'b0, none},
         '{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, none},
         '{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, none},
         '{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, none},
         '{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, none},
         '{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, none},
         '{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, none},
         '{OP_REMOVE, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 1'b1, '{ST_EMPTY, 32'h0, 32'h0, 8'd0}}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_request(directed_rows[i].op, directed_rows[i].val, directed_rows[i].prio,
                       directed_rows[i].typed, directed_rows[i].res);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         steady = (ph == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            op = ($urandom_range(0, 99) < insert_share[ph]) ? OP_INSERT : OP_REMOVE;
            v = $urandom;
            case ($urandom_range(0, 3))
               0: p = $urandom_range(0, 7) - 4;
               1: begin
                  case ($urandom_range(0, 3))
                     0: p = 32'h7fff_ffff;
                     1: p = 32'h8000_0000;
                     2: p = 32'h0000_0000;
                     default: p = 32'hffff_ffff;
                  endcase
               end
               default: p = $urandom;
            endcase
            issue_request(op, v, p, 1'b0, none);
         end
         // after the first phase, hold the request side until every outstanding result is back
         if (ph == 0) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            wait_drained();
         end
      end

      req_tvalid <= 1'b0;
      steady = 1'b0;
      wait_drained();
      repeat (4) @(posedge clock);

      $display("Covered %0d inserts and %0d removes, peak occupancy %0d of %0d",
               n_insert, n_remove, peak_occ, QUEUE_DEPTH);
      $display("Rejected inserts on a full queue: %0d, removes on an empty queue: %0d",
               n_full, n_empty);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sorted_priority_queue.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
verif/tb.sv
